// File: rtl/falfu_pkg.sv
// ----------------------------------------------------------------------------
// falfu_pkg: shared types for the fully associative lfu lookup
// Control groups of the scan token and the commit broadcast, fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package falfu_pkg;

  localparam int unsigned ADDR_BITS  = 32;
  localparam int unsigned TOTAL_BITS = 32;
  localparam int unsigned WAY_FIELD  = 2;

  // control half of the token walking down the cell row
  typedef struct packed {
    logic valid;
    logic found;
  } falfu_scan_t;

  // broadcast from the top level to every cell once the scan is over
  typedef struct packed {
    logic en;
    logic hit;
  } falfu_commit_t;

endpackage

`default_nettype wire

// File: rtl/falfu_cell.sv
// ----------------------------------------------------------------------------
// falfu_cell: one entry of the tag store
// Holds tag, valid and use count; folds its compare and count into the token
// that passes through, and applies the commit aimed at its own index.
// ----------------------------------------------------------------------------
`default_nettype none

module falfu_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned TAG_BITS   = 26,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned WAY_BITS   = 2
) (
  input  wire                          clk,
  input  wire                          rst,
  input  falfu_pkg::falfu_scan_t       scan_in,
  input  wire  [TAG_BITS-1:0]          scan_in_tag,
  input  wire  [WAY_BITS-1:0]          scan_in_hit_way,
  input  wire  [COUNT_BITS:0]          scan_in_best,
  input  wire  [WAY_BITS-1:0]          scan_in_best_way,
  output falfu_pkg::falfu_scan_t       scan_out,
  output logic [TAG_BITS-1:0]          scan_out_tag,
  output logic [WAY_BITS-1:0]          scan_out_hit_way,
  output logic [COUNT_BITS:0]          scan_out_best,
  output logic [WAY_BITS-1:0]          scan_out_best_way,
  input  falfu_pkg::falfu_commit_t     commit,
  input  wire  [WAY_BITS-1:0]          commit_way,
  input  wire  [TAG_BITS-1:0]          commit_tag
);

  import falfu_pkg::*;

  localparam logic [WAY_BITS-1:0] MY_WAY = WAY_BITS'(INDEX);

  logic [TAG_BITS-1:0]   tag;
  logic                  valid;
  logic [COUNT_BITS-1:0] count;

  logic                  match;
  logic [COUNT_BITS:0]   count_eff;
  logic                  mine;

  assign match     = valid && (tag == scan_in_tag);
  // invalid entries compete with a count of zero
  assign count_eff = valid ? {1'b0, count} : '0;
  assign mine      = commit.en && (commit_way == MY_WAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out.valid <= scan_in.valid;
      scan_out.found <= scan_in.found | match;
    end
    scan_out_tag      <= scan_in_tag;
    // first match wins, so later cells leave the way alone
    scan_out_hit_way  <= (!scan_in.found && match) ? MY_WAY : scan_in_hit_way;
    // strict compare keeps the lowest index on ties
    if (count_eff < scan_in_best) begin
      scan_out_best      <= count_eff;
      scan_out_best_way  <= MY_WAY;
    end else begin
      scan_out_best      <= scan_in_best;
      scan_out_best_way  <= scan_in_best_way;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag   <= '1;
      valid <= 1'b0;
      count <= '0;
    end else if (mine) begin
      if (commit.hit) begin
        if (count != '1) begin
          count <= count + COUNT_BITS'(1);
        end
      end else begin
        tag   <= commit_tag;
        valid <= 1'b1;
        count <= COUNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/fully_assoc_lfu_cache_lookup.sv
// ----------------------------------------------------------------------------
// fully_assoc_lfu_cache_lookup: fully associative tag lookup, lfu replacement
// Row of WAYS entry cells scanned by a token, with a commit broadcast.
// ----------------------------------------------------------------------------
// req channel: one word per access, field address. rsp channel: one word per
// access, fields hit, way (low two bits of the entry index) and hits_so_far
// (saturating hit count including this access).
// An accepted address sends a token down the row of cells, one cell per
// cycle; each cell adds its tag compare and its use count to the token. When
// the token leaves the last cell the hit or the lfu victim is known, every
// cell sees the commit and the matching one updates, and the result is loaded
// into the rsp register. Only one access is in the row at a time: a new one is
// taken only after the token walk of the previous one is over.
// req_stall is high while an access is in the row. If rsp is still stalled
// when a result is ready, the result waits in a pending register and req
// stays stalled until the rsp register frees. Reset invalidates every entry,
// clears the use counts and the hit count, and empties both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module fully_assoc_lfu_cache_lookup #(
  parameter int unsigned WAYS        = 4,
  parameter int unsigned OFFSET_BITS = 6,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  req_valid,
  output logic                                 req_stall,
  input  wire  [falfu_pkg::ADDR_BITS-1:0]      address,
  output logic                                 rsp_valid,
  input  wire                                  rsp_stall,
  output logic                                 hit,
  output logic [falfu_pkg::WAY_FIELD-1:0]      way,
  output logic [falfu_pkg::TOTAL_BITS-1:0]     hits_so_far
);

  import falfu_pkg::*;

  localparam int unsigned TAG_BITS = ADDR_BITS - OFFSET_BITS;
  localparam int unsigned WAY_BITS = $clog2(WAYS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PEND
  } state_t;

  state_t state;

  falfu_scan_t         chain      [WAYS+1];
  logic [TAG_BITS-1:0] chain_tag  [WAYS+1];
  logic [WAY_BITS-1:0] chain_hway [WAYS+1];
  logic [COUNT_BITS:0] chain_best [WAYS+1];
  logic [WAY_BITS-1:0] chain_bway [WAYS+1];
  logic [WAYS-1:0]     tok_vld;

  falfu_commit_t       commit;
  logic [WAY_BITS-1:0] commit_way;

  logic [TOTAL_BITS-1:0] hit_total;
  logic [TOTAL_BITS-1:0] hit_total_next;

  logic                  pend_hit;
  logic [WAY_FIELD-1:0]  pend_way;
  logic [TOTAL_BITS-1:0] pend_total;

  logic                  accept;
  logic                  done;
  logic                  rsp_free;
  logic                  rsp_load;
  logic [WAY_BITS+1:0]   way_wide;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign done      = chain[WAYS].valid;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = rsp_free && (((state == ST_SCAN) && done) || (state == ST_PEND));

  // token launch into the first cell
  assign chain[0].valid = accept;
  assign chain[0].found = 1'b0;
  assign chain_tag[0]   = address[ADDR_BITS-1:OFFSET_BITS];
  assign chain_hway[0]  = '0;
  assign chain_best[0]  = {1'b1, {COUNT_BITS{1'b0}}}; // above any real count
  assign chain_bway[0]  = '0;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    assign tok_vld[i] = chain[i+1].valid;

    falfu_cell #(
      .INDEX      (i),
      .TAG_BITS   (TAG_BITS),
      .COUNT_BITS (COUNT_BITS),
      .WAY_BITS   (WAY_BITS)
    ) u_cell (
      .clk               (clk),
      .rst               (rst),
      .scan_in           (chain[i]),
      .scan_in_tag       (chain_tag[i]),
      .scan_in_hit_way   (chain_hway[i]),
      .scan_in_best      (chain_best[i]),
      .scan_in_best_way  (chain_bway[i]),
      .scan_out          (chain[i+1]),
      .scan_out_tag      (chain_tag[i+1]),
      .scan_out_hit_way  (chain_hway[i+1]),
      .scan_out_best     (chain_best[i+1]),
      .scan_out_best_way (chain_bway[i+1]),
      .commit            (commit),
      .commit_way        (commit_way),
      .commit_tag        (chain_tag[WAYS])
    );
  end

  assign commit.en  = done;
  assign commit.hit = chain[WAYS].found;
  assign commit_way = chain[WAYS].found ? chain_hway[WAYS] : chain_bway[WAYS];
  assign way_wide   = {2'b00, commit_way};

  always_comb begin
    hit_total_next = hit_total;
    if (done && chain[WAYS].found && (hit_total != '1)) begin
      hit_total_next = hit_total + TOTAL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      hit_total <= '0;
    end else begin
      hit_total <= hit_total_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (done) begin
            if (rsp_free) begin
              hit         <= chain[WAYS].found;
              way         <= way_wide[1:0];
              hits_so_far <= hit_total_next;
              state       <= ST_IDLE;
            end else begin
              pend_hit   <= chain[WAYS].found;
              pend_way   <= way_wide[1:0];
              pend_total <= hit_total_next;
              state      <= ST_PEND;
            end
          end
        end
        ST_PEND: begin
          if (rsp_free) begin
            hit         <= pend_hit;
            way         <= pend_way;
            hits_so_far <= pend_total;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // at most one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vld))
    else $error("more than one token in the cell row");

  // the token only leaves the row while a scan is in progress
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_SCAN))
    else $error("token left the row outside a scan");

  // a miss never moves the hit count
  a_miss_total: assert property (@(posedge clk) disable iff (rst)
    (commit.en && !commit.hit) |=> (hit_total == $past(hit_total)))
    else $error("hit count changed on a miss");

  // no new access while a result is held back
  a_pend_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PEND) |-> (req_stall && rsp_valid))
    else $error("pending result without a stalled rsp word");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fully_assoc_lfu_cache_lookup
// Drives address words from a queue and predicts hit, way and hit count with
// its own model of the lfu tag store. Every response word is checked field by
// field against the oldest expectation. Both sides idle in random bursts until the tail run.
// A long run of hits on one line builds a large use count to evict around.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WAYS        = 4;
  localparam int unsigned OFFSET_BITS = 6;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned TAG_BITS    = falfu_pkg::ADDR_BITS - OFFSET_BITS;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned TAIL_ITEMS   = 200;
  localparam int unsigned SAT_HITS     = 100;

  typedef struct packed {
    logic                                hit;
    logic [falfu_pkg::WAY_FIELD-1:0]     way;
    logic [falfu_pkg::TOTAL_BITS-1:0]    total;
  } lookup_rsp_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               req_valid = 1'b0;
  logic                               req_stall;
  logic [falfu_pkg::ADDR_BITS-1:0]    address = '0;
  logic                               rsp_valid;
  logic                               rsp_stall = 1'b0;
  logic                               hit;
  logic [falfu_pkg::WAY_FIELD-1:0]    way;
  logic [falfu_pkg::TOTAL_BITS-1:0]   hits_so_far;

  // model of the tag store
  logic [TAG_BITS-1:0]                line_tag [WAYS];
  logic                               line_valid [WAYS];
  logic [COUNT_BITS-1:0]              use_cnt [WAYS];
  logic [falfu_pkg::TOTAL_BITS-1:0]   model_hits;

  logic [falfu_pkg::ADDR_BITS-1:0]    addr_queue [$];
  lookup_rsp_t                        rsp_queue [$];
  logic [TAG_BITS-1:0]                hot_tags [6];
  bit                                 idling_on = 1'b1;
  int unsigned                        req_gap = 0;
  int unsigned                        rsp_gap = 0;
  int unsigned                        mismatches = 0;
  int unsigned                        cycles = 0;

  fully_assoc_lfu_cache_lookup #(
    .WAYS        (WAYS),
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .address     (address),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .way         (way),
    .hits_so_far (hits_so_far)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic lookup_rsp_t predict_lookup(input logic [falfu_pkg::ADDR_BITS-1:0] a);
    logic [TAG_BITS-1:0]   tag;
    int                    idx;
    int                    best;
    logic [COUNT_BITS-1:0] best_cnt;
    logic [COUNT_BITS-1:0] c;
    lookup_rsp_t           r;
    tag = a[falfu_pkg::ADDR_BITS-1:OFFSET_BITS];
    idx = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (idx < 0 && line_valid[w] && line_tag[w] == tag) idx = w;
    end
    if (idx >= 0) begin
      r.hit = 1'b1;
      if (use_cnt[idx] != '1) use_cnt[idx] = use_cnt[idx] + 1'b1;
      if (model_hits != '1) model_hits = model_hits + 1'b1;
    end else begin
      // lfu victim, invalid lines count as zero, ties to the lowest index
      r.hit = 1'b0;
      best = 0;
      best_cnt = line_valid[0] ? use_cnt[0] : '0;
      for (int w = 1; w < WAYS; w++) begin
        c = line_valid[w] ? use_cnt[w] : '0;
        if (c < best_cnt) begin
          best_cnt = c;
          best = w;
        end
      end
      idx = best;
      line_tag[idx] = tag;
      line_valid[idx] = 1'b1;
      use_cnt[idx] = COUNT_BITS'(1);
    end
    r.way = idx[falfu_pkg::WAY_FIELD-1:0];
    r.total = model_hits;
    return r;
  endfunction

  // mostly lines from a small hot set so hits and evictions both happen
  function automatic logic [falfu_pkg::ADDR_BITS-1:0] random_address();
    logic [falfu_pkg::ADDR_BITS-1:0] a;
    if ($urandom_range(0, 19) == 0) hot_tags[$urandom_range(0, 5)] = TAG_BITS'($urandom());
    if ($urandom_range(0, 4) == 0) begin
      a = $urandom();
    end else begin
      a = {hot_tags[$urandom_range(0, 5)], OFFSET_BITS'($urandom())};
    end
    return a;
  endfunction

  // driver: one word per accept, holds the payload while stalled
  always @(posedge clk) begin : drive_req
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) rsp_queue.push_back(predict_lookup(address));
      if (!req_valid || !req_stall) begin
        if (req_gap > 0) begin
          req_gap = req_gap - 1;
          req_valid <= 1'b0;
        end else if (addr_queue.size() > 0) begin
          req_valid <= 1'b1;
          address <= addr_queue.pop_front();
          if (idling_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 19);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted response word against the oldest prediction
  always @(posedge clk) begin : check_rsp
    lookup_rsp_t e;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_queue.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response word: hit %0d way %0d hits_so_far %0d",
                     hit, way, hits_so_far);
          mismatches = mismatches + 1;
        end else begin
          e = rsp_queue.pop_front();
          if (hit !== e.hit || way !== e.way || hits_so_far !== e.total) begin
            if (mismatches < 10)
              $display("mismatch: expected hit %0d way %0d hits_so_far %0d, got %0d %0d %0d",
                       e.hit, e.way, e.total, hit, way, hits_so_far);
            mismatches = mismatches + 1;
          end
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap = rsp_gap - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        if (idling_on && $urandom_range(0, 9) == 0) rsp_gap = $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [falfu_pkg::ADDR_BITS-1:0] sat_line;
    for (int w = 0; w < WAYS; w++) begin
      line_tag[w] = '1;
      line_valid[w] = 1'b0;
      use_cnt[w] = '0;
    end
    model_hits = '0;
    for (int i = 0; i < 6; i++) hot_tags[i] = TAG_BITS'($urandom());

    // all-ones tag must miss against the invalid reset contents
    addr_queue.push_back(32'hFFFF_FFFF);
    addr_queue.push_back(32'hFFFF_FFC0);
    addr_queue.push_back(32'h0000_0000);
    addr_queue.push_back(32'h0000_003F);
    addr_queue.push_back(32'h0000_0040);
    addr_queue.push_back(32'h8000_0000);
    addr_queue.push_back(32'h8000_0001);
    // full store, lowest count gets evicted
    addr_queue.push_back(32'h1234_5678);
    addr_queue.push_back(32'h1234_5640);
    // equal counts, lowest index goes
    addr_queue.push_back(32'hAAAA_AAAA);
    addr_queue.push_back(32'h5555_5555);
    addr_queue.push_back(32'h7FFF_FFFF);
    addr_queue.push_back(32'hFFFF_FFFF);
    addr_queue.push_back(32'h0000_0000);
    addr_queue.push_back(32'h5555_5540);
    addr_queue.push_back(32'hAAAA_AA80);
    for (int i = 0; i < RANDOM_ITEMS; i++) addr_queue.push_back(random_address());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (addr_queue.size() > 0) @(posedge clk);
    idling_on = 1'b0;
    // hammer one line to build a large use count, then keep evicting around it
    sat_line = $urandom();
    for (int i = 0; i < SAT_HITS; i++)
      addr_queue.push_back({sat_line[falfu_pkg::ADDR_BITS-1:OFFSET_BITS],
                            OFFSET_BITS'($urandom())});
    for (int i = 0; i < TAIL_ITEMS; i++) addr_queue.push_back(random_address());

    while (addr_queue.size() > 0 || req_valid || rsp_queue.size() > 0) @(posedge clk);
    repeat (4 * WAYS + 4) @(posedge clk);
    if (mismatches == 0 && rsp_queue.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/falfu_pkg.sv
rtl/falfu_cell.sv
rtl/fully_assoc_lfu_cache_lookup.sv
dv/testbench.sv
